@@ rtl/hdma_pkg.sv @@
// Shared types and constants for the VRAM DMA controller.
// Used by hdma_core and the top level; no dependencies.
package hdma_pkg;

    // Kind of beat on the input stream.
    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_BLANK = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Register window addresses.
    localparam logic [15:0] ADDR_VBK   = 16'hFF4F;
    localparam logic [15:0] ADDR_SRC_H = 16'hFF51;
    localparam logic [15:0] ADDR_SRC_L = 16'hFF52;
    localparam logic [15:0] ADDR_DST_H = 16'hFF53;
    localparam logic [15:0] ADDR_DST_L = 16'hFF54;
    localparam logic [15:0] ADDR_CTRL  = 16'hFF55;

    // Size of one HBlank block in bytes.
    localparam logic [11:0] BLOCK_BYTES = 12'd16;

    // Packed widths of the stream payloads.
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_USED_W  = 57;

    // One accepted input beat.
    typedef struct packed {
        func_t       func;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic        busy_res;
        logic [2:0]  copy_bank;
        logic [11:0] copy_bytes;
        logic [15:0] copy_dest;
        logic [15:0] copy_source;
        logic        copy_valid;
        logic [7:0]  read_data;
    } result_t;

endpackage

@@ rtl/hdma_core.sv @@
// Register file and command logic of the VRAM DMA controller.
// Computes one result per beat and updates the register state when enabled.
// Depends on hdma_pkg.
module hdma_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  hdma_pkg::item_t  item,
    output hdma_pkg::result_t result
);

    // Address registers keep only the upper nibble of the low bytes,
    // since the low nibble is always zero.
    logic [7:0] src_high_reg, src_high_next;
    logic [3:0] src_low_reg,  src_low_next;
    logic [4:0] dst_high_reg, dst_high_next;
    logic [3:0] dst_low_reg,  dst_low_next;
    logic [6:0] blocks_reg,   blocks_next;
    logic       running_reg,  running_next;
    logic       hblank_reg,   hblank_next;
    logic [2:0] bank_reg,     bank_next;

    logic [11:0] src_blk;
    logic [11:0] src_blk_inc;
    logic [8:0]  dst_blk;
    logic [8:0]  dst_blk_inc;
    logic [15:0] cur_src;
    logic [15:0] cur_dst;
    logic        active;

    // Current addresses and their 16-byte increments with wrap.
    assign src_blk     = {src_high_reg, src_low_reg};
    assign src_blk_inc = src_blk + 12'd1;
    assign dst_blk     = {dst_high_reg, dst_low_reg};
    assign dst_blk_inc = dst_blk + 9'd1;
    assign cur_src     = {src_blk, 4'b0000};
    assign cur_dst     = {3'b100, dst_blk, 4'b0000};
    assign active      = running_reg && hblank_reg;

    // Next state and result for the beat in the input register.
    always_comb
    begin
        src_high_next = src_high_reg;
        src_low_next  = src_low_reg;
        dst_high_next = dst_high_reg;
        dst_low_next  = dst_low_reg;
        blocks_next   = blocks_reg;
        running_next  = running_reg;
        hblank_next   = hblank_reg;
        bank_next     = bank_reg;
        result        = '0;

        case (item.func)
            hdma_pkg::FUNC_READ:
            begin
                case (item.bus_address)
                    hdma_pkg::ADDR_SRC_H: result.read_data = src_high_reg;
                    hdma_pkg::ADDR_SRC_L: result.read_data = {src_low_reg, 4'b0000};
                    hdma_pkg::ADDR_DST_H: result.read_data = {3'b000, dst_high_reg};
                    hdma_pkg::ADDR_DST_L: result.read_data = {dst_low_reg, 4'b0000};
                    hdma_pkg::ADDR_CTRL:  result.read_data = {~running_reg, blocks_reg};
                    default:              result.read_data = 8'd0;
                endcase
            end
            hdma_pkg::FUNC_WRITE:
            begin
                case (item.bus_address)
                    hdma_pkg::ADDR_VBK:   bank_next     = item.write_data[2:0];
                    hdma_pkg::ADDR_SRC_H: src_high_next = item.write_data;
                    hdma_pkg::ADDR_SRC_L: src_low_next  = item.write_data[7:4];
                    hdma_pkg::ADDR_DST_H: dst_high_next = item.write_data[4:0];
                    hdma_pkg::ADDR_DST_L: dst_low_next  = item.write_data[7:4];
                    hdma_pkg::ADDR_CTRL:
                    begin
                        if (!item.write_data[7] && active)
                        begin
                            // Cancel of a running HBlank transfer.
                            running_next = 1'b0;
                        end
                        else
                        begin
                            blocks_next = item.write_data[6:0];
                            hblank_next = item.write_data[7];
                            if (!item.write_data[7])
                            begin
                                // General mode: the whole copy in one command.
                                result.copy_valid  = 1'b1;
                                result.copy_source = cur_src;
                                result.copy_dest   = cur_dst;
                                result.copy_bytes  =
                                    {({1'b0, item.write_data[6:0]} + 8'd1), 4'b0000};
                                result.copy_bank   = bank_reg;
                                running_next       = 1'b0;
                            end
                            else
                            begin
                                running_next = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            hdma_pkg::FUNC_BLANK:
            begin
                if (active)
                begin
                    result.copy_valid  = 1'b1;
                    result.copy_source = cur_src;
                    result.copy_dest   = cur_dst;
                    result.copy_bytes  = hdma_pkg::BLOCK_BYTES;
                    result.copy_bank   = bank_reg;
                    {src_high_next, src_low_next} = src_blk_inc;
                    {dst_high_next, dst_low_next} = dst_blk_inc;
                    if (blocks_reg == 7'd0)
                        running_next = 1'b0;
                    else
                        blocks_next = blocks_reg - 7'd1;
                end
            end
            default: ;
        endcase

        result.busy_res = running_next;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_high_reg <= '0;
            src_low_reg  <= '0;
            dst_high_reg <= '0;
            dst_low_reg  <= '0;
            blocks_reg   <= '0;
            running_reg  <= 1'b0;
            hblank_reg   <= 1'b0;
            bank_reg     <= '0;
        end
        else if (en)
        begin
            src_high_reg <= src_high_next;
            src_low_reg  <= src_low_next;
            dst_high_reg <= dst_high_next;
            dst_low_reg  <= dst_low_next;
            blocks_reg   <= blocks_next;
            running_reg  <= running_next;
            hblank_reg   <= hblank_next;
            bank_reg     <= bank_next;
        end
    end

endmodule

@@ rtl/hdma_vram_dma_controller_top.sv @@
// VRAM DMA controller: an accepted input beat passes through the input register, then
// the result register, to its result beat on the master side.
// Throughput is one beat per cycle unless m_tready stalls the result register; the register
// update sits between the two registers, so each beat sees the state left by the one before it.
// Reset (rst_n low, asynchronous) clears both valid flags and the core state registers, empties both stages
// and leaves the controller idle with no transfer running.
module hdma_vram_dma_controller_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [hdma_pkg::IN_TDATA_W-1:0]  s_tdata,  // bus_address[15:0], write_data[23:16]
    input  logic [hdma_pkg::IN_TUSER_W-1:0]  s_tuser,  // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [hdma_pkg::OUT_TDATA_W-1:0] m_tdata   // read_data[7:0], copy_valid[8],
                                                       // copy_source[24:9], copy_dest[40:25],
                                                       // copy_bytes[52:41], copy_bank[55:53],
                                                       // busy_res[56], zeros[63:57]
);

    logic              in_valid_reg;
    hdma_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    hdma_pkg::result_t out_res_reg;
    hdma_pkg::result_t res;
    logic              advance;

    // The input beat moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.func        <= hdma_pkg::func_t'(s_tuser);
            in_item_reg.bus_address <= s_tdata[15:0];
            in_item_reg.write_data  <= s_tdata[23:16];
        end
    end

    // Register file and command logic.
    hdma_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_item_reg),
        .result (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(hdma_pkg::OUT_TDATA_W - hdma_pkg::OUT_USED_W){1'b0}}, out_res_reg};

endmodule

@@ rtl/hdma_checker.sv @@
// Port-level checker for the VRAM DMA controller, bound to the top level.
// Depends only on the top level's ports.
module hdma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Without a copy command all copy fields are zero.
    a_no_copy_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[8] |-> m_tdata[55:9] == 47'd0)
        else $error("copy fields set without a copy command");

    // A read result never carries a copy command.
    a_read_no_copy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7:0] != 8'd0 |-> !m_tdata[8])
        else $error("read data and copy command in one beat");

    // Copies target VRAM, are block aligned and move at least one block.
    a_copy_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |->
            m_tdata[40:38] == 3'b100 && m_tdata[28:25] == 4'd0 &&
            m_tdata[12:9] == 4'd0 && m_tdata[44:41] == 4'd0 && m_tdata[52:41] != 12'd0)
        else $error("malformed copy command");

endmodule

bind hdma_vram_dma_controller_top hdma_checker u_hdma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
